// File: hdl/pmm_pkg.sv
// Shared types and constants for the partition member move block.
`timescale 1ns / 1ps

package pmm_pkg;

  // Default number of elements in the partition.
  localparam int MAX_ELEMENTS_DEF = 256;

  // One input item: the element to move and the set that receives it.
  typedef struct packed {
    logic [7:0] element_index;
    logic [8:0] target_set;
  } pmm_in_t;

  // One result item.
  typedef struct packed {
    logic [8:0] former_set;
    logic [8:0] former_set_size;
    logic [8:0] target_set_size;
  } pmm_out_t;

  // Control word fields that drive the datapath, one flag per microcode step.
  typedef struct packed {
    logic wait_in;
    logic unlink;
    logic drop;
    logic push;
    logic finish;
  } pmm_ctrl_t;

  // Datapath conditions that the sequencer branches on.
  typedef struct packed {
    logic go;
    logic bad_tgt;
  } pmm_stat_t;

endpackage

// File: hdl/pmm_seq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
`timescale 1ns / 1ps

module pmm_seq import pmm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pmm_stat_t stat_i,
  output pmm_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    STEP_WAIT,
    STEP_UNLINK,
    STEP_DROP,
    STEP_PUSH,
    STEP_FINISH
  } step_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_GO,
    COND_BAD_TGT
  } cond_e;

  typedef struct packed {
    pmm_ctrl_t ctrl;
    cond_e     cond;
    step_e     nxt;
    step_e     alt;
  } uword_t;

  // Control store. The jump goes to alt when the condition holds, else to nxt.
  function automatic uword_t urom(step_e s);
    uword_t uw;
    uw      = '0;
    uw.cond = COND_NONE;
    uw.nxt  = STEP_WAIT;
    uw.alt  = STEP_WAIT;
    case (s)
      STEP_WAIT: begin
        uw.ctrl.wait_in = 1'b1;
        uw.cond         = COND_GO;
        uw.nxt          = STEP_WAIT;
        uw.alt          = STEP_UNLINK;
      end
      STEP_UNLINK: begin
        uw.ctrl.unlink = 1'b1;
        uw.nxt         = STEP_DROP;
      end
      STEP_DROP: begin
        uw.ctrl.drop = 1'b1;
        uw.cond      = COND_BAD_TGT;
        uw.nxt       = STEP_PUSH;
        uw.alt       = STEP_WAIT;
      end
      STEP_PUSH: begin
        uw.ctrl.push = 1'b1;
        uw.nxt       = STEP_FINISH;
      end
      STEP_FINISH: begin
        uw.ctrl.finish = 1'b1;
        uw.nxt         = STEP_WAIT;
      end
      default: begin
        uw.nxt = STEP_WAIT;
      end
    endcase
    return uw;
  endfunction

  step_e  step_q, step_d;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = urom(step_q);
    case (uw.cond)
      COND_GO:      take = stat_i.go;
      COND_BAD_TGT: take = stat_i.bad_tgt;
      default:      take = 1'b0;
    endcase
    step_d = take ? uw.alt : uw.nxt;
  end

  assign ctrl_o = uw.ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// File: hdl/partition_member_move_top.sv
// Top level of the partition member move block: tables, datapath and handshakes.
`timescale 1ns / 1ps

// The block keeps MAX_ELEMENTS elements split into disjoint sets, each set a
// doubly linked list with a head and a member count. An input item names an
// element and a target set; if both are in range, the element is unlinked from
// its set and pushed at the head of the target set. Each item yields exactly
// one result item; for a move it holds the former set, its size after removal
// and the target set's size after insertion.
// Both channels use valid and stall; an item moves at a rising edge where
// valid is high and stall is low. The result sits in an output register, so
// a new item can be accepted while the previous result is still stalled.
// A move runs the microcode steps unlink, drop, push and finish, one dependent
// table read and write at a time, before the next item is accepted. An
// out-of-range target ends after drop with the element left in place, and an
// out-of-range element is answered at acceptance. A result passes from a
// holding register to the output register. When the receiver stalls, one
// finished result waits in the holding register, and further input stalls.
// After reset the tables are rebuilt by a clearing pass over set ids 0 to
// MAX_ELEMENTS, which chains all elements in order in set 0; input is stalled
// throughout.

module partition_member_move_top import pmm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pmm_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pmm_out_t out_data_o
);

  localparam int EW = $clog2(MAX_ELEMENTS);
  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ELEMENTS);

  function automatic logic is_elem(logic [LW-1:0] x);
    return 32'(x) < MAX_ELEMENTS;
  endfunction

  // Element tables and set tables.
  logic [LW-1:0] sid_mem  [MAX_ELEMENTS];
  logic [LW-1:0] next_mem [MAX_ELEMENTS];
  logic [LW-1:0] prev_mem [MAX_ELEMENTS];
  logic [LW-1:0] head_mem [MAX_ELEMENTS+1];
  logic [LW-1:0] cnt_mem  [MAX_ELEMENTS+1];

  logic [LW-1:0] sid_rd_q, next_rd_q, prev_rd_q, head_rd_q, cnt_rd_q;

  // Write ports and read addresses.
  logic          sid_we, next_we, prev_we, head_we, cnt_we;
  logic [EW-1:0] sid_wa, next_wa, prev_wa, elem_ra;
  logic [LW-1:0] head_wa, cnt_wa, head_ra, cnt_ra;
  logic [LW-1:0] sid_wd, next_wd, prev_wd, head_wd, cnt_wd;

  // Sequencer interface.
  pmm_ctrl_t ctrl;
  pmm_stat_t stat;

  // Item registers.
  logic [EW-1:0] v_q;
  logic [LW-1:0] to_q;
  logic          tgt_ok_q;
  logic [LW-1:0] from_q;
  logic [LW-1:0] fsize_q;

  // Clearing pass.
  logic          clr_q;
  logic [LW-1:0] clr_cnt_q;
  logic          clr_elem;

  // Result path.
  logic     res_set;
  pmm_out_t res_d, res_q, out_q;
  logic     pend_q, out_valid_q, out_free;

  logic          accept, elem_ok;
  logic [LW-1:0] from_w, dec_w, inc_w;

  pmm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = clr_q | ~ctrl.wait_in | (pend_q & ~out_free);
  assign accept     = in_valid_i & ~in_stall_o;
  assign elem_ok    = 32'(in_data_i.element_index) < MAX_ELEMENTS;

  assign stat.go      = accept & elem_ok;
  assign stat.bad_tgt = ~tgt_ok_q;

  // A stored set id is always in range; the guard maps a stray value to set 0.
  assign from_w = (32'(sid_rd_q) <= MAX_ELEMENTS) ? sid_rd_q : '0;
  assign dec_w  = (cnt_rd_q == '0) ? '0 : cnt_rd_q - 1'b1;
  assign inc_w  = cnt_rd_q + 1'b1;

  assign clr_elem = clr_q && (32'(clr_cnt_q) < MAX_ELEMENTS);

  assign elem_ra = EW'(in_data_i.element_index);
  assign head_ra = to_q;
  assign cnt_ra  = ctrl.unlink ? from_w : to_q;

  // Write port selection. Each step touches each table at most once.
  always_comb begin
    sid_we  = 1'b0;
    sid_wa  = v_q;
    sid_wd  = to_q;
    next_we = 1'b0;
    next_wa = v_q;
    next_wd = head_rd_q;
    prev_we = 1'b0;
    prev_wa = v_q;
    prev_wd = NULL_LINK;
    head_we = 1'b0;
    head_wa = to_q;
    head_wd = LW'(v_q);
    cnt_we  = 1'b0;
    cnt_wa  = to_q;
    cnt_wd  = inc_w;

    if (clr_q) begin
      sid_we  = clr_elem;
      sid_wa  = clr_cnt_q[EW-1:0];
      sid_wd  = '0;
      next_we = clr_elem;
      next_wa = clr_cnt_q[EW-1:0];
      next_wd = clr_cnt_q + 1'b1;
      prev_we = clr_elem;
      prev_wa = clr_cnt_q[EW-1:0];
      prev_wd = (clr_cnt_q == '0) ? NULL_LINK : clr_cnt_q - 1'b1;
      head_we = 1'b1;
      head_wa = clr_cnt_q;
      head_wd = (clr_cnt_q == '0) ? '0 : NULL_LINK;
      cnt_we  = 1'b1;
      cnt_wa  = clr_cnt_q;
      cnt_wd  = (clr_cnt_q == '0) ? LW'(MAX_ELEMENTS) : '0;
    end else if (ctrl.unlink) begin
      // Bridge the neighbors, or move the head when the element led its set.
      next_we = tgt_ok_q & is_elem(prev_rd_q);
      next_wa = prev_rd_q[EW-1:0];
      next_wd = next_rd_q;
      prev_we = tgt_ok_q & is_elem(next_rd_q);
      prev_wa = next_rd_q[EW-1:0];
      prev_wd = prev_rd_q;
      head_we = tgt_ok_q & ~is_elem(prev_rd_q);
      head_wa = from_w;
      head_wd = next_rd_q;
    end else if (ctrl.drop) begin
      cnt_we = tgt_ok_q;
      cnt_wa = from_q;
      cnt_wd = dec_w;
    end else if (ctrl.push) begin
      sid_we  = 1'b1;
      next_we = 1'b1;
      prev_we = is_elem(head_rd_q);
      prev_wa = head_rd_q[EW-1:0];
      prev_wd = LW'(v_q);
      head_we = 1'b1;
    end else if (ctrl.finish) begin
      prev_we = 1'b1;
      cnt_we  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sid_we) begin
      sid_mem[sid_wa] <= sid_wd;
    end
    sid_rd_q <= sid_mem[elem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_q <= next_mem[elem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_q <= prev_mem[elem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // Result formation.
  always_comb begin
    res_set = 1'b0;
    res_d   = '0;
    if (accept && !elem_ok) begin
      res_set = 1'b1;
    end else if (ctrl.drop && !tgt_ok_q) begin
      res_set                 = 1'b1;
      res_d.former_set        = 9'(from_q);
      res_d.former_set_size   = 9'(cnt_rd_q);
    end else if (ctrl.finish) begin
      res_set                 = 1'b1;
      res_d.former_set        = 9'(from_q);
      res_d.former_set_size   = 9'(fsize_q);
      res_d.target_set_size   = 9'(inc_w);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q      <= EW'(in_data_i.element_index);
      to_q     <= LW'(in_data_i.target_set);
      tgt_ok_q <= 32'(in_data_i.target_set) <= MAX_ELEMENTS;
    end
    if (ctrl.unlink) begin
      from_q <= from_w;
    end
    if (ctrl.drop) begin
      fsize_q <= dec_w;
    end
    if (res_set) begin
      res_q <= res_d;
    end
    if (pend_q && out_free) begin
      out_q <= res_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_cnt_q == NULL_LINK) begin
          clr_q <= 1'b0;
        end else begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
        end
      end
      pend_q <= res_set | (pend_q & ~out_free);
      if (pend_q && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/pmm_chk.sv
// Port-level checker for the partition member move block and its bind.
`timescale 1ns / 1ps

module pmm_chk import pmm_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input pmm_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input pmm_out_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Set ids reported are always within the partition.
  a_set_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_data_o.former_set) <= MAX_ELEMENTS)
    else $error("former set id out of range");

  // No set can hold more members than there are elements.
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.former_set_size) <= MAX_ELEMENTS) &&
                    (32'(out_data_o.target_set_size) <= MAX_ELEMENTS))
    else $error("set size out of range");

  // A move of a real element keeps the input stalled on the next cycle.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (32'(in_data_i.element_index) < MAX_ELEMENTS) |=> in_stall_o)
    else $error("input taken while a move is in progress");

endmodule

bind partition_member_move_top pmm_chk #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_pmm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
